/* rtl/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg - shared types and constants for the point projection core
// Register indexes, the configuration bundle, component extraction and
// the datapath widths used across the pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

    // configuration register indexes
    localparam logic [3:0] CFG_OBJ_ORIGIN = 4'd0;
    localparam logic [3:0] CFG_OBJ_AXIS_U = 4'd1;
    localparam logic [3:0] CFG_OBJ_AXIS_V = 4'd2;
    localparam logic [3:0] CFG_OBJ_AXIS_W = 4'd3;
    localparam logic [3:0] CFG_CAM_ORG_ZM = 4'd4;
    localparam logic [3:0] CFG_CAM_AXIS_U = 4'd5;
    localparam logic [3:0] CFG_CAM_AXIS_V = 4'd6;
    localparam logic [3:0] CFG_CAM_AXIS_W = 4'd7;

    // zoom 1.0 in Q8.8
    localparam logic signed [15:0] ZOOM_ONE = 16'sd256;

    // datapath widths
    localparam int D_W    = 25;   // direction, Q.12
    localparam int DOT_W  = 43;   // camera axis dot direction
    localparam int NUM_W  = 59;   // dot product times zoom
    localparam int DIV_BITS = 16; // quotient bits resolved below the overflow test

    // configuration seen by the datapath
    typedef struct packed {
        logic [47:0]        obj_origin;
        logic [47:0]        obj_u;
        logic [47:0]        obj_v;
        logic [47:0]        obj_w;
        logic [47:0]        cam_origin;
        logic signed [15:0] zoom;
        logic [47:0]        cam_u;
        logic [47:0]        cam_v;
        logic [47:0]        cam_w;
    } t_cfg;

    // one input point, Q8.8
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_point;

    // signed 16-bit component of a packed triple, x in the low bits
    function automatic logic signed [15:0] comp(input logic [47:0] w, input logic [1:0] i);
        logic signed [15:0] r;
        r = w[16*i +: 16];
        return r;
    endfunction

endpackage

/* rtl/perspective_point_projection_core.sv */
// ----------------------------------------------------------------------------
// perspective_point_projection_core - fixed-point point projection
// Maps object-local points through the object frame, makes them relative
// to the camera eye and projects them onto the camera plane.
// ----------------------------------------------------------------------------
// One point per cycle sustained while the output is not stalled. The restoring
// divider resolves one quotient bit per stage for both screen axes. Stalls on the
// output back up stage by stage, so empty stages keep filling. Configuration
// writes are taken every cycle and must only happen while no point is in
// flight.
module perspective_point_projection_core
    import ppp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input points
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // local_x, local_y, local_z
    // results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // screen_x, screen_y
    output logic [0:0]  o_m_tuser    // visible
);

    logic [47:0]        r_obj_origin, r_obj_u, r_obj_v, r_obj_w;
    logic [47:0]        r_cam_origin, r_cam_u, r_cam_v, r_cam_w;
    logic signed [15:0] r_zoom;
    t_cfg               cfg;
    t_point             pt;

    logic                    xf_valid, xf_ready;
    logic signed [D_W-1:0]   xf_d [3];
    logic                    dt_valid, dt_ready, dt_vis;
    logic signed [NUM_W-1:0] dt_nx, dt_ny;
    logic [DOT_W-1:0]        dt_den;
    logic signed [15:0]      dv_sx, dv_sy;
    logic                    dv_vis;

    // configuration registers, out-of-range indexes dropped
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_origin <= '0;
            r_obj_u      <= '0;
            r_obj_v      <= '0;
            r_obj_w      <= '0;
            r_cam_origin <= '0;
            r_zoom       <= ZOOM_ONE;
            r_cam_u      <= '0;
            r_cam_v      <= '0;
            r_cam_w      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OBJ_ORIGIN: r_obj_origin <= i_cfg_data[47:0];
                CFG_OBJ_AXIS_U: r_obj_u      <= i_cfg_data[47:0];
                CFG_OBJ_AXIS_V: r_obj_v      <= i_cfg_data[47:0];
                CFG_OBJ_AXIS_W: r_obj_w      <= i_cfg_data[47:0];
                CFG_CAM_ORG_ZM: begin
                    r_cam_origin <= i_cfg_data[63:16];
                    r_zoom       <= i_cfg_data[15:0];
                end
                CFG_CAM_AXIS_U: r_cam_u      <= i_cfg_data[47:0];
                CFG_CAM_AXIS_V: r_cam_v      <= i_cfg_data[47:0];
                CFG_CAM_AXIS_W: r_cam_w      <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // configuration bundle
    always_comb begin
        cfg.obj_origin = r_obj_origin;
        cfg.obj_u      = r_obj_u;
        cfg.obj_v      = r_obj_v;
        cfg.obj_w      = r_obj_w;
        cfg.cam_origin = r_cam_origin;
        cfg.zoom       = r_zoom;
        cfg.cam_u      = r_cam_u;
        cfg.cam_v      = r_cam_v;
        cfg.cam_w      = r_cam_w;
    end

    assign pt = t_point'(i_s_tdata);

    // frame transform
    ppp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_pt    (pt),
        .o_valid (xf_valid),
        .i_ready (xf_ready),
        .o_d     (xf_d)
    );

    // camera dot products
    ppp_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (xf_valid),
        .o_ready (xf_ready),
        .i_d     (xf_d),
        .o_valid (dt_valid),
        .i_ready (dt_ready),
        .o_nx    (dt_nx),
        .o_ny    (dt_ny),
        .o_den   (dt_den),
        .o_vis   (dt_vis)
    );

    // perspective divide
    ppp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dt_valid),
        .o_ready (dt_ready),
        .i_nx    (dt_nx),
        .i_ny    (dt_ny),
        .i_den   (dt_den),
        .i_vis   (dt_vis),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_sx    (dv_sx),
        .o_sy    (dv_sy),
        .o_vis   (dv_vis)
    );

    assign o_m_tdata    = {dv_sy, dv_sx};
    assign o_m_tuser[0] = dv_vis;

`ifndef SYNTHESIS
    // hidden points carry zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 32'd0)
        else $error("hidden point with nonzero coordinates");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a non-positive zoom never yields a visible point
    a_zoom_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_zoom <= 16'sd0 |-> !o_m_tuser[0])
        else $error("visible point with non-positive zoom");
`endif

endmodule

/* rtl/ppp_xform.sv */
// ----------------------------------------------------------------------------
// ppp_xform - object to eye-relative direction
// Two stages: axis products and eye position, then the world sum minus the
// eye, rounded down to Q.12.
// ----------------------------------------------------------------------------
module ppp_xform
    import ppp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_point                i_pt,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [D_W-1:0] o_d [3]
);

    logic               r_v1, r_v2;
    logic               en1, en2;
    logic signed [29:0] r_org [3];
    logic signed [31:0] r_pu [3];
    logic signed [31:0] r_pv [3];
    logic signed [31:0] r_pw [3];
    logic signed [31:0] r_eye [3];
    logic signed [29:0] n_org [3];
    logic signed [31:0] n_pu [3];
    logic signed [31:0] n_pv [3];
    logic signed [31:0] n_pw [3];
    logic signed [31:0] n_eye [3];
    logic signed [34:0] n_sum [3];
    logic signed [D_W-1:0] r_d [3];

    // stall chain
    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;

    // stage 1: local axis products and eye position
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_org[j] = 30'(comp(i_cfg.obj_origin, 2'(j))) <<< 14;
            n_pu[j]  = 32'(comp(i_cfg.obj_u, 2'(j)) * i_pt.x);
            n_pv[j]  = 32'(comp(i_cfg.obj_v, 2'(j)) * i_pt.y);
            n_pw[j]  = 32'(comp(i_cfg.obj_w, 2'(j)) * i_pt.z);
            n_eye[j] = (32'(comp(i_cfg.cam_origin, 2'(j))) <<< 14)
                     - 32'(comp(i_cfg.cam_w, 2'(j)) * i_cfg.zoom);
        end
    end

    // stage 2: world minus eye, floor to Q.12
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sum[j] = 35'(r_org[j]) + 35'(r_pu[j]) + 35'(r_pv[j]) + 35'(r_pw[j])
                     - 35'(r_eye[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (en1) begin
                r_org[j] <= n_org[j];
                r_pu[j]  <= n_pu[j];
                r_pv[j]  <= n_pv[j];
                r_pw[j]  <= n_pw[j];
                r_eye[j] <= n_eye[j];
            end
            if (en2) r_d[j] <= n_sum[j][34:10];
        end
    end

    assign o_d = r_d;

endmodule

/* rtl/ppp_dot.sv */
// ----------------------------------------------------------------------------
// ppp_dot - camera axis dot products and depth test
// Three stages: axis products, sums, then zoom scaling of the numerators
// alongside the visibility compare.
// ----------------------------------------------------------------------------
module ppp_dot
    import ppp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [D_W-1:0]   i_d [3],
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [NUM_W-1:0] o_nx,
    output logic signed [NUM_W-1:0] o_ny,
    output logic [DOT_W-1:0]        o_den,
    output logic                    o_vis
);

    localparam int P_W = D_W + 16;

    logic r_v3, r_v4, r_v5;
    logic en3, en4, en5;
    logic signed [P_W-1:0]   r_pu [3];
    logic signed [P_W-1:0]   r_pv [3];
    logic signed [P_W-1:0]   r_pw [3];
    logic signed [DOT_W-1:0] r_du, r_dv, r_dw;
    logic signed [NUM_W-1:0] r_nx, r_ny;
    logic [DOT_W-1:0]        r_den;
    logic                    r_vis;
    logic                    n_vis;

    // stall chain
    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;
    assign o_valid = r_v5;

    // depth at least the zoom and zoom positive
    assign n_vis = (i_cfg.zoom > 16'sd0) && (r_dw >= (DOT_W'(i_cfg.zoom) <<< 18));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en3) r_v3 <= i_valid;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 3: per-component products
    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int j = 0; j < 3; j++) begin
                r_pu[j] <= P_W'(comp(i_cfg.cam_u, 2'(j)) * i_d[j]);
                r_pv[j] <= P_W'(comp(i_cfg.cam_v, 2'(j)) * i_d[j]);
                r_pw[j] <= P_W'(comp(i_cfg.cam_w, 2'(j)) * i_d[j]);
            end
        end
    end

    // stage 4: dot sums
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_du <= DOT_W'(r_pu[0]) + DOT_W'(r_pu[1]) + DOT_W'(r_pu[2]);
            r_dv <= DOT_W'(r_pv[0]) + DOT_W'(r_pv[1]) + DOT_W'(r_pv[2]);
            r_dw <= DOT_W'(r_pw[0]) + DOT_W'(r_pw[1]) + DOT_W'(r_pw[2]);
        end
    end

    // stage 5: numerators scaled by zoom, depth test
    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_nx  <= NUM_W'(r_du * i_cfg.zoom);
            r_ny  <= NUM_W'(r_dv * i_cfg.zoom);
            r_den <= r_dw;
            r_vis <= n_vis;
        end
    end

    assign o_nx  = r_nx;
    assign o_ny  = r_ny;
    assign o_den = r_den;
    assign o_vis = r_vis;

endmodule

/* rtl/ppp_div.sv */
// ----------------------------------------------------------------------------
// ppp_div - pipelined restoring divider with saturation
// Magnitude stage, overflow test, one quotient bit per stage for both
// screen axes against a shared depth, then sign, saturation and masking
// into the output register.
// ----------------------------------------------------------------------------
module ppp_div
    import ppp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [NUM_W-1:0] i_nx,
    input  logic signed [NUM_W-1:0] i_ny,
    input  logic [DOT_W-1:0]        i_den,
    input  logic                    i_vis,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [15:0]      o_sx,
    output logic signed [15:0]      o_sy,
    output logic                    o_vis
);

    localparam int NS = DIV_BITS + 1;

    // magnitude stage
    logic                r_va, en_a;
    logic [NUM_W-1:0]    r_ax, r_ay;
    logic                r_sxa, r_sya, r_visa;
    logic [DOT_W-1:0]    r_dena;

    // overflow stage at index 0, bit stages after it
    logic                r_vs [NS];
    logic                en_s [NS];
    logic [NUM_W-1:0]    r_rx [NS];
    logic [NUM_W-1:0]    r_ry [NS];
    logic [DIV_BITS-1:0] r_qx [NS];
    logic [DIV_BITS-1:0] r_qy [NS];
    logic                r_ox [NS];
    logic                r_oy [NS];
    logic                r_sx [NS];
    logic                r_sy [NS];
    logic                r_vi [NS];
    logic [DOT_W-1:0]    r_dn [NS];
    logic [NUM_W-1:0]    n_rx [NS];
    logic [NUM_W-1:0]    n_ry [NS];
    logic [DIV_BITS-1:0] n_qx [NS];
    logic [DIV_BITS-1:0] n_qy [NS];
    logic [NUM_W-1:0]    n_trial [NS];

    // output register
    logic                r_vo, en_o;
    logic signed [15:0]  r_osx, r_osy;
    logic                r_ovis;
    logic signed [15:0]  n_osx, n_osy;

    // stall chain
    assign en_o = !r_vo || i_ready;
    always_comb begin
        en_s[NS-1] = !r_vs[NS-1] || en_o;
        for (int k = NS - 2; k >= 0; k--) begin
            en_s[k] = !r_vs[k] || en_s[k+1];
        end
    end
    assign en_a    = !r_va || en_s[0];
    assign o_ready = en_a;
    assign o_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k < NS; k++) r_vs[k] <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_s[0]) r_vs[0] <= r_va;
            for (int k = 1; k < NS; k++) begin
                if (en_s[k]) r_vs[k] <= r_vs[k-1];
            end
            if (en_o) r_vo <= r_vs[NS-1];
        end
    end

    // magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_ax   <= i_nx[NUM_W-1] ? NUM_W'(-i_nx) : NUM_W'(i_nx);
            r_ay   <= i_ny[NUM_W-1] ? NUM_W'(-i_ny) : NUM_W'(i_ny);
            r_sxa  <= i_nx[NUM_W-1];
            r_sya  <= i_ny[NUM_W-1];
            r_dena <= i_den;
            r_visa <= i_vis;
        end
    end

    // trial subtraction for each bit stage
    always_comb begin
        n_rx[0]    = '0;
        n_ry[0]    = '0;
        n_qx[0]    = '0;
        n_qy[0]    = '0;
        n_trial[0] = '0;
        for (int k = 1; k < NS; k++) begin
            n_trial[k] = NUM_W'(r_dn[k-1]) << (DIV_BITS - k);
            if (r_rx[k-1] >= n_trial[k]) begin
                n_rx[k] = r_rx[k-1] - n_trial[k];
                n_qx[k] = r_qx[k-1] | (DIV_BITS'(1) << (DIV_BITS - k));
            end else begin
                n_rx[k] = r_rx[k-1];
                n_qx[k] = r_qx[k-1];
            end
            if (r_ry[k-1] >= n_trial[k]) begin
                n_ry[k] = r_ry[k-1] - n_trial[k];
                n_qy[k] = r_qy[k-1] | (DIV_BITS'(1) << (DIV_BITS - k));
            end else begin
                n_ry[k] = r_ry[k-1];
                n_qy[k] = r_qy[k-1];
            end
        end
    end

    // overflow test and bit stages
    always_ff @(posedge i_clk) begin
        if (en_s[0]) begin
            r_rx[0] <= r_ax;
            r_ry[0] <= r_ay;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_ox[0] <= r_ax >= {r_dena, DIV_BITS'(0)};
            r_oy[0] <= r_ay >= {r_dena, DIV_BITS'(0)};
            r_sx[0] <= r_sxa;
            r_sy[0] <= r_sya;
            r_vi[0] <= r_visa;
            r_dn[0] <= r_dena;
        end
        for (int k = 1; k < NS; k++) begin
            if (en_s[k]) begin
                r_rx[k] <= n_rx[k];
                r_ry[k] <= n_ry[k];
                r_qx[k] <= n_qx[k];
                r_qy[k] <= n_qy[k];
                r_ox[k] <= r_ox[k-1];
                r_oy[k] <= r_oy[k-1];
                r_sx[k] <= r_sx[k-1];
                r_sy[k] <= r_sy[k-1];
                r_vi[k] <= r_vi[k-1];
                r_dn[k] <= r_dn[k-1];
            end
        end
    end

    // sign, saturation and masking
    always_comb begin
        if (!r_vi[NS-1]) begin
            n_osx = '0;
        end else if (r_ox[NS-1] || r_qx[NS-1][DIV_BITS-1]) begin
            n_osx = r_sx[NS-1] ? -16'sd32768 : 16'sd32767;
        end else begin
            n_osx = r_sx[NS-1] ? -$signed(r_qx[NS-1]) : $signed(r_qx[NS-1]);
        end
        if (!r_vi[NS-1]) begin
            n_osy = '0;
        end else if (r_oy[NS-1] || r_qy[NS-1][DIV_BITS-1]) begin
            n_osy = r_sy[NS-1] ? -16'sd32768 : 16'sd32767;
        end else begin
            n_osy = r_sy[NS-1] ? -$signed(r_qy[NS-1]) : $signed(r_qy[NS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_osx  <= n_osx;
            r_osy  <= n_osy;
            r_ovis <= r_vi[NS-1];
        end
    end

    assign o_sx  = r_osx;
    assign o_sy  = r_osy;
    assign o_vis = r_ovis;

endmodule
